/* rtl/core/lhci_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lhci_pkg;

	// table geometry
	localparam int MAX_HASH_BITS = 15;
	localparam int WINDOW_BITS   = 15;
	localparam int BKT_W         = MAX_HASH_BITS;
	localparam int POS_W         = WINDOW_BITS;
	localparam int HB_W          = $clog2(MAX_HASH_BITS + 1);

	// stream payload widths
	localparam int OUT_W       = 15;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 48;

	localparam logic [31:0] HASH_MULT     = 32'h1E35A7BD;
	localparam logic [3:0]  HASH_BITS_RST = 4'd15;

	// register index, taken from paddr[2]
	localparam logic REG_HASH_BITS = 1'b0;

	// window leaving the front stage
	typedef struct packed {
		logic             valid;
		logic [31:0]      prod;
		logic [POS_W-1:0] pos;
	} lhci_win_t;

endpackage

`default_nettype wire

/* rtl/core/lhci_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module lhci_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/lhci_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module lhci_front import lhci_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       in_acc,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output lhci_win_t       win_s1
);

	logic [23:0]      recent_q;
	logic [1:0]       seen_q;
	logic [POS_W-1:0] wpos_q;
	logic [31:0]      word;
	logic             full;

	logic             v_s1;
	logic [31:0]      prod_s1;
	logic [POS_W-1:0] pos_s1;

	assign word = {in_byte, recent_q};
	assign full = (seen_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			seen_q   <= '0;
			wpos_q   <= '0;
		end else if (in_acc) begin
			if (in_last) begin
				recent_q <= '0;
				seen_q   <= '0;
				wpos_q   <= '0;
			end else if (full) begin
				recent_q <= word[31:8];
				wpos_q   <= wpos_q + 1'b1;
			end else begin
				recent_q <= {in_byte, recent_q[23:8]};
				seen_q   <= seen_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_acc && full;
		end
	end

	// hash multiply, low 32 bits kept
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= word * HASH_MULT;
			pos_s1  <= wpos_q;
		end
	end

	assign win_s1 = '{valid: v_s1, prod: prod_s1, pos: pos_s1};

endmodule

`default_nettype wire

/* rtl/core/lhci_chain.sv */
`timescale 1ns / 1ps
`default_nettype none

module lhci_chain import lhci_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [3:0]       cfg_hbits,
	input  wire lhci_win_t        win_s1,
	input  wire logic             out_ready,
	output logic                  en,
	output logic                  clr_busy,
	output logic                  out_valid,
	output logic      [OUT_W-1:0] out_bucket,
	output logic      [OUT_W-1:0] out_pos,
	output logic      [OUT_W-1:0] out_prev
);

	logic [HB_W-1:0]  eff_bits;
	logic [5:0]       shamt;
	logic [31:0]      shifted;
	logic [BKT_W-1:0] bkt_s1;

	logic             v_s2;
	logic [BKT_W-1:0] bkt_s2;
	logic [POS_W-1:0] pos_s2;

	logic             last_v_q;
	logic [BKT_W-1:0] last_bkt_q;
	logic [POS_W-1:0] last_pos_q;

	logic             clr_busy_q;
	logic [BKT_W-1:0] clr_cnt_q;

	logic             out_valid_q;
	logic [OUT_W-1:0] out_bucket_q;
	logic [OUT_W-1:0] out_pos_q;
	logic [OUT_W-1:0] out_prev_q;

	logic [POS_W-1:0] head_rd;
	logic [POS_W-1:0] prev_head;
	logic [BKT_W-1:0] head_raddr;
	logic             head_we;
	logic [BKT_W-1:0] head_waddr;
	logic [POS_W-1:0] head_wdata;
	logic             wr_ins;

	// clamp to [1, MAX_HASH_BITS]
	always_comb begin
		if (cfg_hbits == 4'd0) begin
			eff_bits = HB_W'(1);
		end else if (HB_W'(cfg_hbits) > HB_W'(MAX_HASH_BITS)) begin
			eff_bits = HB_W'(MAX_HASH_BITS);
		end else begin
			eff_bits = HB_W'(cfg_hbits);
		end
	end

	assign shamt   = 6'd32 - 6'(eff_bits);
	assign shifted = win_s1.prod >> shamt;
	assign bkt_s1  = shifted[BKT_W-1:0];

	assign en     = !out_valid_q || out_ready;
	assign wr_ins = en && v_s2;

	// on a stall, re-read the held bucket so the data stays current
	assign head_raddr = en ? bkt_s1 : bkt_s2;

	// last insert is not yet visible in the read data
	assign prev_head = (last_v_q && (last_bkt_q == bkt_s2)) ? last_pos_q : head_rd;

	assign head_we    = clr_busy_q || wr_ins;
	assign head_waddr = clr_busy_q ? clr_cnt_q : bkt_s2;
	assign head_wdata = clr_busy_q ? '0 : pos_s2;

	lhci_ram #(
		.WIDTH (POS_W),
		.DEPTH (1 << BKT_W)
	) u_head_ram (
		.clk     (clk),
		.we      (head_we),
		.waddr   (head_waddr),
		.wdata   (head_wdata),
		.raddr   (head_raddr),
		.rd_data (head_rd)
	);

	// prev links: write-only here
	lhci_ram #(
		.WIDTH (POS_W),
		.DEPTH (1 << POS_W)
	) u_prev_ram (
		.clk     (clk),
		.we      (wr_ins),
		.waddr   (pos_s2),
		.wdata   (prev_head),
		.raddr   (pos_s2),
		.rd_data ()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_cnt_q   <= '0;
			v_s2        <= 1'b0;
			last_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (en) begin
				v_s2        <= win_s1.valid;
				out_valid_q <= v_s2;
			end
			if (wr_ins) begin
				last_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bkt_s2 <= bkt_s1;
			pos_s2 <= win_s1.pos;
		end
		if (wr_ins) begin
			last_bkt_q   <= bkt_s2;
			last_pos_q   <= pos_s2;
			out_bucket_q <= OUT_W'(bkt_s2);
			out_pos_q    <= OUT_W'(pos_s2);
			out_prev_q   <= OUT_W'(prev_head);
		end
	end

	assign clr_busy   = clr_busy_q;
	assign out_valid  = out_valid_q;
	assign out_bucket = out_bucket_q;
	assign out_pos    = out_pos_q;
	assign out_prev   = out_prev_q;

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!v_s2 && !out_valid_q))
		else $error("insert in flight during head clear");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && v_s2) |=> (v_s2 && $stable(bkt_s2) && $stable(pos_s2)))
		else $error("stage 2 lost its insert on a stall");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> (clr_cnt_q == '0))
		else $error("head clear ended before covering every bucket");

endmodule

`default_nettype wire

/* rtl/core/lz77_hash_chain_insert_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// A byte closing a window is registered in the front stage, in stage 2 and in the output
// register, which drives m_axis_tvalid. One byte per cycle while m_axis_tready keeps up
// and no head clear runs; the head RAM is read one stage ahead and the previous insert is
// forwarded past the read-first collision, so back-to-back inserts never stall. Reset
// (arst_n, async, active low): hash width returns to 15, byte window empties, and all
// 2^MAX_HASH_BITS = 32768 head buckets are cleared with s_axis_tready low.

module lz77_hash_chain_insert_core import lhci_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	// byte stream
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic                   s_axis_tlast,  // last_byte

	// insert records
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // [14:0] bucket_index,
	                                                   // [29:15] insert_position,
	                                                   // [44:30] chain_previous

	// config port
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [2:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic      [31:0]            prdata,
	output logic                        pready
);

	logic [3:0]       hbits_q;
	logic             cfg_wr;
	logic             in_acc;
	logic             en;
	logic             clr_busy;
	lhci_win_t        win_s1;
	logic [OUT_W-1:0] out_bucket;
	logic [OUT_W-1:0] out_pos;
	logic [OUT_W-1:0] out_prev;

	// config register; the user writes it only while the block is idle, the block does not enforce this
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hbits_q <= HASH_BITS_RST;
		end else if (cfg_wr && (paddr[2] == REG_HASH_BITS)) begin
			hbits_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr[2] == REG_HASH_BITS) ? {28'd0, hbits_q} : 32'd0;

	// input side stalls with the pipeline and during the head clear
	assign s_axis_tready = en && !clr_busy;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// byte window, position count and hash multiply
	lhci_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_acc  (in_acc),
		.in_byte (s_axis_tdata[7:0]),
		.in_last (s_axis_tlast),
		.win_s1  (win_s1)
	);

	// bucket select, head read-modify-write with forwarding, prev write, output register
	lhci_chain u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_hbits  (hbits_q),
		.win_s1     (win_s1),
		.out_ready  (m_axis_tready),
		.en         (en),
		.clr_busy   (clr_busy),
		.out_valid  (m_axis_tvalid),
		.out_bucket (out_bucket),
		.out_pos    (out_pos),
		.out_prev   (out_prev)
	);

	assign m_axis_tdata = {3'd0, out_prev, out_pos, out_bucket};

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

// Hash-chain inserter bench.
// A byte stream with buffer marks drives s_axis, and the inserter's records on m_axis
// are checked against a local chain model that keeps its own head table and window.
// Sender and receiver both idle at random. The hash width register is changed only
// with the stream drained.
module testbench import lhci_pkg::*;;

	localparam int          CLK_HALF     = 5;
	localparam int          RESET_CYCLES = 8;
	// Quiet edges after the last record before a register write. Bytes that make no
	// record can still be in flight in the core's front stage and stage 2.
	localparam int          DRAIN_CYCLES = 8;
	// The head clear after reset keeps tready low while it walks all 32768 buckets; allow for it.
	localparam int          STALL_LIMIT  = 100000;
	localparam int          LONG_LEN     = 250;
	localparam int          PHASES       = 8;
	localparam int          PHASE_BYTES  = 190;
	localparam logic [2:0]  ADDR_HBITS    = 3'd0;
	localparam logic [2:0]  ADDR_UNMAPPED = 3'd4;    // register index 1, unmapped

	typedef enum int {MIX_RANDOM, MIX_NARROW, MIX_EXTREME} byte_mix_t;

	typedef struct packed {
		logic [BKT_W-1:0] bucket;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] prev;
	} insert_rec_t;

	// DUT inputs, all known from time 0
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;    // [7:0] data_byte
	logic                  s_axis_tlast  = 1'b0;  // last_byte
	logic                  m_axis_tready = 1'b0;
	logic                  psel          = 1'b0;
	logic                  penable       = 1'b0;
	logic                  pwrite        = 1'b0;
	logic [2:0]            paddr         = '0;
	logic [31:0]           pwdata        = '0;

	// DUT outputs
	logic                   s_axis_tready;
	logic                   m_axis_tvalid;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [14:0] bucket_index, [29:15] insert_position,
	                                        // [44:30] chain_previous
	logic [31:0]            prdata;
	logic                   pready;

	// chain model state
	logic [3:0]       cfg_hbits     = HASH_BITS_RST;
	logic [23:0]      win_bytes     = '0;  // oldest byte in [7:0]
	int unsigned      held_bytes    = 0;   // saturates at three
	logic [POS_W-1:0] next_pos      = '0;
	logic [POS_W-1:0] head_mem [0:(1 << MAX_HASH_BITS)-1];

	insert_rec_t expected_inserts[$];
	insert_rec_t exp_rec;

	// bench control and tallies
	bit          quiet       = 1'b0;  // no idling on either side while set
	int unsigned n_errors    = 0;
	int unsigned n_bytes     = 0;
	int unsigned n_buffers   = 0;
	int unsigned n_records   = 0;
	int unsigned n_cfg       = 0;
	int unsigned idle_cycles = 0;

	lz77_hash_chain_insert_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		foreach (head_mem[i]) head_mem[i] = '0;
	end

	// One byte through the chain model: a record comes out once four bytes are held.
	task automatic index_byte(input logic [7:0] b, input logic last);
		logic [31:0] word;
		logic [31:0] prod;
		int          bits;
		insert_rec_t rec;
		if (held_bytes >= 3) begin
			word = {b, win_bytes};
			// a hash width of zero acts as one
			bits = (cfg_hbits < 1) ? 1 : int'(cfg_hbits);
			if (bits > MAX_HASH_BITS) bits = MAX_HASH_BITS;
			prod = word * HASH_MULT;
			rec.bucket = BKT_W'(prod >> (32 - bits));
			rec.pos    = next_pos;
			rec.prev   = head_mem[rec.bucket];
			head_mem[rec.bucket] = next_pos;
			expected_inserts.push_back(rec);
			win_bytes = word[31:8];
			next_pos  = next_pos + 1'b1;   // wraps with the window
		end else begin
			win_bytes  = {b, win_bytes[23:8]};
			held_bytes = held_bytes + 1;
		end
		// buffer end: window restarts, tables are kept
		if (last) begin
			win_bytes  = '0;
			held_bytes = 0;
			next_pos   = '0;
			n_buffers++;
		end
	endtask

	// Leaves tvalid high; whoever waits next lowers it.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!quiet && $urandom_range(99) < 20) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		index_byte(b, last);
		n_bytes++;
	endtask

	// Stop sending and wait until every record is back.
	task automatic drain_records();
		s_axis_tvalid <= 1'b0;
		while (expected_inserts.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		drain_records();
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[2] == REG_HASH_BITS) cfg_hbits = value[3:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		n_cfg++;
	endtask

	// Upper write-data bits are junk; only [3:0] count.
	task automatic set_hbits(input logic [3:0] hb);
		write_reg(ADDR_HBITS, {28'($urandom() >> 4), hb});
	endtask

	function automatic logic [7:0] pick_byte(input byte_mix_t mix);
		case (mix)
			MIX_NARROW:  return 8'($urandom_range(3));          // repeats, collisions
			MIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
			default:     return 8'($urandom());
		endcase
	endfunction

	task automatic send_buffer(input int len, input byte_mix_t mix);
		for (int i = 0; i < len; i++) send_byte(pick_byte(mix), i == len - 1);
	endtask

	// Buffers of one to three bytes insert nothing, and each one resets the window.
	task automatic test_short_buffers();
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b1);
	endtask

	// All-zero window, then windows ending in one to three all-ones bytes; reset hash width.
	task automatic test_byte_extremes();
		for (int i = 0; i < 4; i++) send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	// Zero acts as one bit; one bit; a write to the unmapped index must be ignored.
	task automatic test_hbits_limits();
		set_hbits(4'd0);
		send_buffer(5, MIX_RANDOM);
		set_hbits(4'd1);
		send_buffer(4, MIX_RANDOM);
		write_reg(ADDR_UNMAPPED, $urandom());
		send_buffer(4, MIX_RANDOM);
	endtask

	// One long buffer with no idle-free gaps forced, so positions run far past the start.
	task automatic test_long_buffer();
		set_hbits(4'($urandom_range(15, 8)));
		send_buffer(LONG_LEN, MIX_RANDOM);
	endtask

	task automatic test_random_buffers();
		int        sent;
		int        len;
		bit        paused;
		byte_mix_t mix;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       set_hbits(4'd15);
				1:       set_hbits(4'd0);
				2:       set_hbits(4'd1);
				default: set_hbits(4'($urandom_range(15)));
			endcase
			quiet  = (phase == 3);
			sent   = 0;
			paused = 1'b0;
			while (sent < PHASE_BYTES) begin
				case ($urandom_range(9))
					0:       len = $urandom_range(3, 1);
					1:       len = $urandom_range(120, 41);
					default: len = $urandom_range(40, 4);
				endcase
				case ($urandom_range(5))
					0:       mix = MIX_NARROW;
					1:       mix = MIX_EXTREME;
					default: mix = MIX_RANDOM;
				endcase
				for (int i = 0; i < len; i++) begin
					send_byte(pick_byte(mix), i == len - 1);
					sent++;
					// sender holds off mid-buffer until the core has caught up
					if (phase == 5 && !paused && sent > PHASE_BYTES / 2) begin
						drain_records();
						paused = 1'b1;
					end
				end
			end
			quiet = 1'b0;
		end
	endtask

	// receiver backpressure
	always @(posedge clk) begin
		m_axis_tready <= quiet || ($urandom_range(99) >= 20);
	end

	function automatic void check_field(input string name, input logic [14:0] want,
	                                    input logic [14:0] got);
		if (want !== got) begin
			n_errors++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	// record checker, oldest expectation first
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_inserts.size() == 0) begin
				n_errors++;
				$error("insert record with nothing expected: tdata %h", m_axis_tdata);
			end else begin
				exp_rec = expected_inserts.pop_front();
				check_field("bucket_index",    exp_rec.bucket, m_axis_tdata[14:0]);
				check_field("insert_position", exp_rec.pos,    m_axis_tdata[29:15]);
				check_field("chain_previous",  exp_rec.prev,   m_axis_tdata[44:30]);
				n_records++;
			end
		end
	end

	// watchdog: cycles with no transfer on any port
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (psel && penable && pready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_short_buffers();
		test_byte_extremes();
		test_hbits_limits();
		test_long_buffer();
		test_random_buffers();

		drain_records();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d bytes in %0d buffers, %0d insert records, %0d register writes,",
		         n_bytes, n_buffers, n_records, n_cfg);
		$display("     hash widths from 0 to 15, bucket collisions and short and long buffers.");
		if (n_errors == 0 && expected_inserts.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
